// ===== src/i2cbm_pkg.sv =====
// Shared types and constants for the I2C bit-level master.
package i2cbm_pkg;

    localparam int unsigned HP_W = 8;

    localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 8'h10;

    localparam logic [2:0] MODE_TICK       = 3'd0;
    localparam logic [2:0] MODE_START      = 3'd1;
    localparam logic [2:0] MODE_STOP       = 3'd2;
    localparam logic [2:0] MODE_WRITE      = 3'd3;
    localparam logic [2:0] MODE_READ_ACK   = 3'd4;
    localparam logic [2:0] MODE_READ_NOACK = 3'd5;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_ST_A   = 4'd1,
        PH_ST_B   = 4'd2,
        PH_SP_A   = 4'd3,
        PH_SP_B   = 4'd4,
        PH_WR_LO  = 4'd5,
        PH_WR_HI  = 4'd6,
        PH_WA_LO  = 4'd7,
        PH_WA_HI  = 4'd8,
        PH_WA_END = 4'd9,
        PH_RD_LO  = 4'd10,
        PH_RD_HI  = 4'd11,
        PH_RA_1   = 4'd12,
        PH_RA_2   = 4'd13,
        PH_RA_3   = 4'd14
    } phase_t;

    // One input beat.
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] write_data;
        logic       sda_in;
    } cmd_t;

    // Handshake between input stage and engine.
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

// ===== src/i2cbm_in_stage.sv =====
// Input register stage of the I2C bit-level master.
module i2cbm_in_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  i2cbm_pkg::cmd_t       cmd_in,
    input  logic                  advance,
    output i2cbm_pkg::cmd_t       cmd_reg,
    output logic                  valid_reg
);

    logic load;

    // Stage is free when empty or when its beat moves on this cycle.
    assign load     = !valid_reg || advance;
    assign in_stall = !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            cmd_reg <= cmd_in;
        end
    end

endmodule

// ===== src/i2cbm_engine.sv =====
// Bus sequencer state and result register of the I2C bit-level master.
module i2cbm_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [i2cbm_pkg::HP_W-1:0]    half_period,
    input  i2cbm_pkg::cmd_t               cmd,
    input  i2cbm_pkg::stage_ctl_t         ctl,
    output logic                          scl_out,
    output logic                          sda_out,
    output logic                          busy_res,
    output logic                          done_res
,   output logic [7:0]                    read_data,
    output logic                          ack_bit
);

    i2cbm_pkg::phase_t          phase_reg, phase_next;
    logic                       ack_cmd_reg, ack_cmd_next;
    logic [3:0]                 bit_reg, bit_next;
    logic [7:0]                 shift_reg, shift_next;
    logic [i2cbm_pkg::HP_W-1:0] wait_reg, wait_next;
    logic                       scl_reg, scl_next;
    logic                       sda_reg, sda_next;
    logic                       ack_reg, ack_next;
    logic [7:0]                 hold_reg, hold_next;
    logic                       done_reg, done_next;
    logic [i2cbm_pkg::HP_W-1:0] arm_ticks;
    logic                       fire;
    logic                       fin;
    logic [7:0]                 shifted;
    logic [3:0]                 bit_inc;

    assign fire      = ctl.valid && ctl.advance;
    // A setting of zero behaves as one tick.
    assign arm_ticks = (half_period == '0) ? {{(i2cbm_pkg::HP_W-1){1'b0}}, 1'b1} : half_period;
    assign bit_inc   = bit_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= i2cbm_pkg::PH_IDLE;
            ack_cmd_reg <= 1'b0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            wait_reg    <= '0;
            scl_reg     <= 1'b0;
            sda_reg     <= 1'b1;
            ack_reg     <= 1'b1;
            hold_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            ack_cmd_reg <= ack_cmd_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            wait_reg    <= wait_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            ack_reg     <= ack_next;
            hold_reg    <= hold_next;
            done_reg    <= done_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        ack_cmd_next = ack_cmd_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        wait_next    = wait_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        ack_next     = ack_reg;
        hold_next    = hold_reg;
        done_next    = done_reg;
        fin          = 1'b0;
        shifted      = '0;

        if (fire)
        begin
            done_next = 1'b0;
            if (cmd.mode == i2cbm_pkg::MODE_TICK)
            begin
                if (phase_reg != i2cbm_pkg::PH_IDLE)
                begin
                    if (wait_reg > {{(i2cbm_pkg::HP_W-1){1'b0}}, 1'b1})
                    begin
                        wait_next = wait_reg - {{(i2cbm_pkg::HP_W-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        // Delay over: apply the line changes up to the next delay.
                        wait_next = arm_ticks;
                        case (phase_reg)
                            i2cbm_pkg::PH_ST_A:
                            begin
                                sda_next   = 1'b0;
                                phase_next = i2cbm_pkg::PH_ST_B;
                            end
                            i2cbm_pkg::PH_ST_B:
                            begin
                                scl_next = 1'b0;
                                fin      = 1'b1;
                            end
                            i2cbm_pkg::PH_SP_A:
                            begin
                                scl_next   = 1'b1;
                                phase_next = i2cbm_pkg::PH_SP_B;
                            end
                            i2cbm_pkg::PH_SP_B:
                            begin
                                sda_next = 1'b1;
                                fin      = 1'b1;
                            end
                            i2cbm_pkg::PH_WR_LO:
                            begin
                                scl_next   = 1'b1;
                                phase_next = i2cbm_pkg::PH_WR_HI;
                            end
                            i2cbm_pkg::PH_WR_HI:
                            begin
                                scl_next   = 1'b0;
                                shifted    = {shift_reg[6:0], 1'b0};
                                shift_next = shifted;
                                bit_next   = bit_inc;
                                if (bit_inc < i2cbm_pkg::BITS_PER_BYTE)
                                begin
                                    sda_next   = shifted[7];
                                    phase_next = i2cbm_pkg::PH_WR_LO;
                                end
                                else
                                begin
                                    sda_next   = 1'b1;
                                    phase_next = i2cbm_pkg::PH_WA_LO;
                                end
                            end
                            i2cbm_pkg::PH_WA_LO:
                            begin
                                scl_next   = 1'b1;
                                phase_next = i2cbm_pkg::PH_WA_HI;
                            end
                            i2cbm_pkg::PH_WA_HI:
                            begin
                                ack_next   = cmd.sda_in;
                                scl_next   = 1'b0;
                                phase_next = i2cbm_pkg::PH_WA_END;
                            end
                            i2cbm_pkg::PH_WA_END:
                            begin
                                fin = 1'b1;
                            end
                            i2cbm_pkg::PH_RD_LO:
                            begin
                                scl_next   = 1'b1;
                                phase_next = i2cbm_pkg::PH_RD_HI;
                            end
                            i2cbm_pkg::PH_RD_HI:
                            begin
                                shifted    = {shift_reg[6:0], cmd.sda_in};
                                shift_next = shifted;
                                scl_next   = 1'b0;
                                bit_next   = bit_inc;
                                if (bit_inc < i2cbm_pkg::BITS_PER_BYTE)
                                begin
                                    phase_next = i2cbm_pkg::PH_RD_LO;
                                end
                                else
                                begin
                                    hold_next  = shifted;
                                    sda_next   = !ack_cmd_reg;
                                    phase_next = i2cbm_pkg::PH_RA_1;
                                end
                            end
                            i2cbm_pkg::PH_RA_1:
                            begin
                                phase_next = i2cbm_pkg::PH_RA_2;
                            end
                            i2cbm_pkg::PH_RA_2:
                            begin
                                scl_next   = 1'b1;
                                phase_next = i2cbm_pkg::PH_RA_3;
                            end
                            i2cbm_pkg::PH_RA_3:
                            begin
                                // No-ack leaves SCL high; ack releases SDA.
                                scl_next = !ack_cmd_reg;
                                if (ack_cmd_reg)
                                begin
                                    sda_next = 1'b1;
                                end
                                fin = 1'b1;
                            end
                            default:
                            begin
                                fin = 1'b1;
                            end
                        endcase
                        if (fin)
                        begin
                            phase_next = i2cbm_pkg::PH_IDLE;
                            wait_next  = '0;
                            done_next  = 1'b1;
                        end
                    end
                end
            end
            else if (phase_reg == i2cbm_pkg::PH_IDLE &&
                     cmd.mode <= i2cbm_pkg::MODE_READ_NOACK)
            begin
                ack_cmd_next = (cmd.mode == i2cbm_pkg::MODE_READ_ACK);
                bit_next     = '0;
                wait_next    = arm_ticks;
                case (cmd.mode)
                    i2cbm_pkg::MODE_START:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        phase_next = i2cbm_pkg::PH_ST_A;
                    end
                    i2cbm_pkg::MODE_STOP:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = i2cbm_pkg::PH_SP_A;
                    end
                    i2cbm_pkg::MODE_WRITE:
                    begin
                        shift_next = cmd.write_data;
                        sda_next   = cmd.write_data[7];
                        phase_next = i2cbm_pkg::PH_WR_LO;
                    end
                    default:
                    begin
                        shift_next = '0;
                        phase_next = i2cbm_pkg::PH_RD_LO;
                    end
                endcase
            end
        end
    end

    // State changes only when a beat moves into the result slot, so the
    // state registers double as the result register.
    assign scl_out   = scl_reg;
    assign sda_out   = sda_reg;
    assign busy_res  = (phase_reg != i2cbm_pkg::PH_IDLE);
    assign done_res  = done_reg;
    assign read_data = hold_reg;
    assign ack_bit   = ack_reg;

endmodule

// ===== src/i2cbm_out_ctl.sv =====
// Result slot valid tracking for the I2C bit-level master.
module i2cbm_out_ctl
(
    input  logic clk,
    input  logic rst_n,
    input  logic stage_valid,
    input  logic out_stall,
    output logic out_valid,
    output logic advance
);

    logic out_valid_reg, out_valid_next;

    // Slot can take a new beat when empty or being drained this cycle.
    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = stage_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/i2c_bit_level_master.sv =====
// Top level of the I2C bit-level master.
//
// Bit-level I2C master. Each input beat is either a command (start, stop,
// write byte, read then ack, read then no-ack) or a time tick carrying the
// sampled SDA pin; every accepted beat yields exactly one result beat with
// the driven SCL/SDA levels, busy, done, the last read byte and the last
// write acknowledge (0 = acked). Each delay phase of a command lasts
// half_period_ticks ticks (0 acts as 1, reset value 16). Commands sent
// while busy, and modes 6 and 7, leave the state untouched apart from
// clearing done, but still produce a result. Throughput is one beat per
// clock while out_stall is low; a beat passes the input register and then
// the sequencer, whose state registers also hold the result. A stall on
// the result side backs up into in_stall after the input register fills.
// The configuration register must only be written while no beat is in
// flight.
module i2c_bit_level_master
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] mode,
    input  logic [7:0] write_data,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_out,
    output logic       sda_out,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] read_data,
    output logic       ack_bit
);

    logic [i2cbm_pkg::HP_W-1:0] half_period_reg;
    i2cbm_pkg::cmd_t            cmd_in;
    i2cbm_pkg::cmd_t            cmd_reg;
    i2cbm_pkg::stage_ctl_t      ctl;
    logic                       stage_valid;
    logic                       advance;

    // Delay setting register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= i2cbm_pkg::HALF_PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            half_period_reg <= cfg_wr_data;
        end
    end

    assign cmd_in.mode       = mode;
    assign cmd_in.write_data = write_data;
    assign cmd_in.sda_in     = sda_in;

    i2cbm_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd_in    (cmd_in),
        .advance   (advance),
        .cmd_reg   (cmd_reg),
        .valid_reg (stage_valid)
    );

    i2cbm_out_ctl u_out_ctl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .advance     (advance)
    );

    assign ctl.valid   = stage_valid;
    assign ctl.advance = advance;

    // Sequencer: one state step per beat moved into the result slot.
    i2cbm_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_period (half_period_reg),
        .cmd         (cmd_reg),
        .ctl         (ctl),
        .scl_out     (scl_out),
        .sda_out     (sda_out),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .read_data   (read_data),
        .ack_bit     (ack_bit)
    );

endmodule
